>>> rtl/core/sc2c_pkg.sv
package sc2c_pkg;

    // Default ring depth of the character queue.
    localparam int FIFO_DEPTH_DEF = 1024;

    // Scan codes with a meaning of their own.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_FORCE_CAPS   = 8'h27;
    localparam logic [7:0] SC_ARROW_UP     = 8'd72;
    localparam logic [7:0] SC_ARROW_DOWN   = 8'd80;
    localparam logic [7:0] SC_ARROW_LEFT   = 8'd75;
    localparam logic [7:0] SC_ARROW_RIGHT  = 8'd77;
    localparam logic [7:0] SC_TABLE_LIMIT  = 8'd58;

    // Characters produced by the arrow keys.
    localparam logic [7:0] CH_ARROW_UP    = 8'h80;
    localparam logic [7:0] CH_ARROW_DOWN  = 8'h81;
    localparam logic [7:0] CH_ARROW_LEFT  = 8'h82;
    localparam logic [7:0] CH_ARROW_RIGHT = 8'h83;

    // Word index of the layout register on the configuration port.
    localparam logic REG_LAYOUT = 1'b0;

    typedef enum logic [1:0] {
        CMD_SCAN  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd_code;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_rd;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic rd_pending;
    } t_dp_sts;

    // Each entry is {shifted, unshifted}. Entries past the table range are zero.
    localparam logic [15:0] KEY_EN [0:63] = '{
        16'h0000, 16'h1B1B, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
        16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
        16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
        16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'h0000, 16'h4161, 16'h5373,
        16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
        16'h2227, 16'h7E60, 16'h0000, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
        16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'h0000, 16'h0000,
        16'h0000, 16'h2020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    // Spanish layout; the non-ASCII keys carry Latin-1 codes.
    localparam logic [15:0] KEY_ES [0:63] = '{
        16'h0000, 16'h1B1B, 16'h2131, 16'h2232, 16'h2333, 16'h2434, 16'h2535, 16'h2636,
        16'h2F37, 16'h2838, 16'h2939, 16'h3D30, 16'h3F27, 16'hA1BF, 16'h0808, 16'h0909,
        16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
        16'h4F6F, 16'h5070, 16'h2260, 16'h2A2B, 16'h0A0A, 16'h0000, 16'h4161, 16'h5373,
        16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h7E7F,
        16'h5B7B, 16'h7E60, 16'h0000, 16'h5D7D, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
        16'h4262, 16'h4E6E, 16'h4D6D, 16'h3B2C, 16'h3A2E, 16'h5F2D, 16'h0000, 16'h0000,
        16'h0000, 16'h2020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    function automatic logic [15:0] key_lookup(input logic lay, input logic [5:0] code);
        return lay ? KEY_ES[code] : KEY_EN[code];
    endfunction

endpackage

>>> rtl/core/scancode_to_char_fifo.sv
// Scan code to character queue. Each input transfer carries a command: a set-1
// scan code to translate and queue, a pop of the oldest character, a peek at the
// newest one, or a clear. Shift and caps lock are tracked from the code stream,
// and the layout register (English 0, Spanish 1, reset 1) selects the table;
// arrow keys queue 0x80 to 0x83. Every command gives exactly one result transfer
// with the character read (zero for anything that is not a successful read), the
// fill level after the command, and a done flag. One item is handled at a time:
// a scan code, a clear, or a pop or peek on an empty queue passes through capture,
// execution and the result hold before the next input transfer can be taken, and
// a pop or peek that finds a character adds a wait for the registered read of the
// character memory. While the output is stalled the result is held and the input
// stays stalled. The queue holds FIFO_DEPTH characters in one RAM and needs no
// clearing pass after reset.
module scancode_to_char_fifo #(
    parameter int FIFO_DEPTH = sc2c_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_command,
    input  logic [7:0]                      i_scan_code,
    // Output channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_char_out,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_fill_level,
    output logic                            o_done_res,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    sc2c_pkg::t_dp_cmd dp_cmd;
    sc2c_pkg::t_dp_sts dp_sts;
    logic              r_layout;
    logic              cfg_write;

    // The configuration port never inserts wait states. Address bit 2
    // selects the register; only the layout register exists.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= 1'b1;
        end else if (cfg_write && (paddr[2] == sc2c_pkg::REG_LAYOUT)) begin
            r_layout <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == sc2c_pkg::REG_LAYOUT) ? {31'd0, r_layout} : 32'd0;

    // The controller sequences capture, execution, the memory read wait and the
    // result hold; the datapath owns the pointers, the key state and the RAM.
    sc2c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    sc2c_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_layout     (r_layout),
        .i_command    (i_command),
        .i_scan_code  (i_scan_code),
        .o_char_out   (o_char_out),
        .o_fill_level (o_fill_level),
        .o_done_res   (o_done_res)
    );

    // A result waiting to be taken always holds off the next input.
    a_result_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted while a result is pending");

    // An accepted item keeps the input stalled in the following cycle.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a transfer");

    // A result that reads nothing carries a zero character.
    a_no_read_zero_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_char_out == 8'h00))
        else $error("nonzero character without a completed read or store");

    // The fill level of a result never exceeds the queue depth.
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill_level <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH)))
        else $error("fill level beyond depth");

endmodule

>>> rtl/core/sc2c_ram.sv
module sc2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sc2c_pkg::FIFO_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sc2c_datapath.sv
module sc2c_datapath #(
    parameter int FIFO_DEPTH = sc2c_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sc2c_pkg::t_dp_cmd               i_cmd,
    output sc2c_pkg::t_dp_sts               o_sts,
    input  logic                            i_layout,
    input  logic [1:0]                      i_command,
    input  logic [7:0]                      i_scan_code,
    output logic [7:0]                      o_char_out,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_fill_level,
    output logic                            o_done_res
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    sc2c_pkg::t_cmd_code r_command;
    logic [7:0]          r_code;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_shift, n_shift;
    logic                r_caps, n_caps;
    logic [7:0]          r_char;
    logic [CNT_W-1:0]    r_fill;
    logic                r_done;

    logic [15:0]      key_pair;
    logic             in_table;
    logic             is_arrow;
    logic             is_letter;
    logic             use_hi;
    logic             fifo_full;
    logic             fifo_empty;
    logic             push_en;
    logic             done_exec;
    logic [7:0]       push_char;
    logic [7:0]       arrow_char;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       ram_rdata;

    assign fifo_full  = (r_count == CNT_FULL);
    assign fifo_empty = (r_count == '0);

    // Key translation for the captured scan code.
    always_comb begin
        key_pair  = sc2c_pkg::key_lookup(i_layout, r_code[5:0]);
        in_table  = (r_code != 8'd0) && (r_code < sc2c_pkg::SC_TABLE_LIMIT);
        is_letter = (r_code == sc2c_pkg::SC_FORCE_CAPS)
                 || ((key_pair[7:0] >= 8'h61) && (key_pair[7:0] <= 8'h7A));
        is_arrow  = 1'b1;
        case (r_code)
            sc2c_pkg::SC_ARROW_UP:    arrow_char = sc2c_pkg::CH_ARROW_UP;
            sc2c_pkg::SC_ARROW_DOWN:  arrow_char = sc2c_pkg::CH_ARROW_DOWN;
            sc2c_pkg::SC_ARROW_LEFT:  arrow_char = sc2c_pkg::CH_ARROW_LEFT;
            sc2c_pkg::SC_ARROW_RIGHT: arrow_char = sc2c_pkg::CH_ARROW_RIGHT;
            default: begin
                arrow_char = 8'h00;
                is_arrow   = 1'b0;
            end
        endcase
    end

    // Next state of one executed command.
    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_shift   = r_shift;
        n_caps    = r_caps;
        push_en   = 1'b0;
        done_exec = 1'b0;
        use_hi    = 1'b0;
        push_char = 8'h00;
        rd_addr   = r_rd_ptr;
        unique case (r_command)
            sc2c_pkg::CMD_SCAN: begin
                if ((r_code == sc2c_pkg::SC_LSHIFT_MAKE)
                        || (r_code == sc2c_pkg::SC_RSHIFT_MAKE)) begin
                    n_shift = 1'b1;
                end else if ((r_code == sc2c_pkg::SC_LSHIFT_BREAK)
                        || (r_code == sc2c_pkg::SC_RSHIFT_BREAK)) begin
                    n_shift = 1'b0;
                end else if (r_code == sc2c_pkg::SC_CAPS_MAKE) begin
                    n_caps = ~r_caps;
                end
                // Caps lock takes effect on the key that toggles it as well.
                use_hi    = (is_letter && n_caps) || n_shift;
                push_char = in_table ? (use_hi ? key_pair[15:8] : key_pair[7:0])
                                     : arrow_char;
                push_en   = (in_table || is_arrow) && !fifo_full;
                done_exec = push_en;
                if (push_en) begin
                    n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            sc2c_pkg::CMD_POP: begin
                if (!fifo_empty) begin
                    n_rd_ptr  = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                    n_count   = r_count - 1'b1;
                    done_exec = 1'b1;
                end
            end
            sc2c_pkg::CMD_PEEK: begin
                rd_addr   = (r_wr_ptr == '0) ? PTR_LAST : r_wr_ptr - 1'b1;
                done_exec = !fifo_empty;
            end
            sc2c_pkg::CMD_CLEAR: begin
                n_rd_ptr = '0;
                n_wr_ptr = '0;
                n_count  = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_sts.rd_pending = ((r_command == sc2c_pkg::CMD_POP)
                            || (r_command == sc2c_pkg::CMD_PEEK)) && !fifo_empty;

    sc2c_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && push_en),
        .i_waddr (r_wr_ptr),
        .i_wdata (push_char),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_caps   <= n_caps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= sc2c_pkg::t_cmd_code'(i_command);
            r_code    <= i_scan_code;
        end
        if (i_cmd.exec) begin
            r_char <= 8'h00;
            r_fill <= n_count;
            r_done <= done_exec;
        end else if (i_cmd.load_rd) begin
            r_char <= ram_rdata;
        end
    end

    assign o_char_out   = r_char;
    assign o_fill_level = r_fill;
    assign o_done_res   = r_done;

endmodule

>>> rtl/core/sc2c_ctrl.sv
module sc2c_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  sc2c_pkg::t_dp_sts i_sts,
    output sc2c_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_RDWAIT = 4'b0100,
        ST_OUT    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.rd_pending ? ST_RDWAIT : ST_OUT;
            end
            ST_RDWAIT: begin
                o_cmd.load_rd = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

endmodule
